// File: rtl/core/upd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_pkg
// Shared types, character constants and hex helpers for the URL percent
// decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

  localparam logic [7:0] CH_PCT   = 8'h25;  // '%'
  localparam logic [7:0] CH_0     = 8'h30;  // '0'
  localparam logic [7:0] CH_9     = 8'h39;  // '9'
  localparam logic [7:0] CH_LA    = 8'h61;  // 'a'
  localparam logic [7:0] CH_LF    = 8'h66;  // 'f'
  localparam logic [7:0] CH_UA    = 8'h41;  // 'A'
  localparam logic [7:0] CH_UF    = 8'h46;  // 'F'
  localparam logic [3:0] HEX_TEN  = 4'd10;

  localparam int unsigned MAX_BYTES = 3;
  localparam int unsigned CNT_W     = 2;   // holds 0..MAX_BYTES
  localparam int unsigned Q_DEPTH   = 2;

  typedef struct packed {
    logic [7:0] in_char;
    logic       is_final;
  } in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       run_last;
    logic       string_end;
  } out_t;

  // One transaction's worth of result bytes, handed from front to back.
  typedef struct packed {
    logic [CNT_W-1:0]               cnt;
    logic [MAX_BYTES-1:0][7:0]      bytes;
    logic                           fin;
  } plan_t;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = ((c >= CH_0)  && (c <= CH_9))  ||
             ((c >= CH_LA) && (c <= CH_LF)) ||
             ((c >= CH_UA) && (c <= CH_UF));
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if ((c >= CH_0) && (c <= CH_9)) begin
      d = c - CH_0;
    end else if ((c >= CH_LA) && (c <= CH_LF)) begin
      d = c - CH_LA + {4'd0, HEX_TEN};
    end else if ((c >= CH_UA) && (c <= CH_UF)) begin
      d = c - CH_UA + {4'd0, HEX_TEN};
    end
    hex_val = d[3:0];
  endfunction

endpackage

// File: rtl/core/upd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_front
// Escape tracker: classifies each character and builds the list of result
// bytes it causes.
// ----------------------------------------------------------------------------
module upd_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  upd_pkg::in_t   in_data,
  input  logic           q_full,
  output logic           q_push,
  output upd_pkg::plan_t q_plan
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PCT,
    PH_DIGIT
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] held_r, held_nxt;

  upd_pkg::plan_t plan;
  logic [7:0]     c;

  always_comb begin
    c         = in_data.in_char;
    plan      = '0;
    plan.fin  = in_data.is_final;
    phase_nxt = PH_IDLE;
    held_nxt  = held_r;

    case (phase_r)
      PH_PCT: begin
        if (upd_pkg::is_hex(c)) begin
          held_nxt  = c;
          phase_nxt = PH_DIGIT;
        end else begin
          plan.bytes[0] = upd_pkg::CH_PCT;
          plan.cnt      = 2'd1;
        end
      end
      PH_DIGIT: begin
        if (upd_pkg::is_hex(c)) begin
          plan.bytes[0] = {upd_pkg::hex_val(held_r), upd_pkg::hex_val(c)};
          plan.cnt      = 2'd1;
        end else begin
          plan.bytes[0] = upd_pkg::CH_PCT;
          plan.bytes[1] = held_r;
          plan.cnt      = 2'd2;
        end
      end
      default: begin
        plan.cnt = 2'd0;
      end
    endcase

    // Fresh character: idle state, or the one that broke an escape.
    if ((phase_r != PH_PCT && phase_r != PH_DIGIT) || !upd_pkg::is_hex(c)) begin
      if (c == upd_pkg::CH_PCT) begin
        phase_nxt = PH_PCT;
      end else begin
        plan.bytes[plan.cnt] = c;
        plan.cnt             = plan.cnt + 2'd1;
      end
    end

    // End of string: flush whatever is still held.
    if (in_data.is_final) begin
      if (phase_nxt == PH_PCT) begin
        plan.bytes[plan.cnt] = upd_pkg::CH_PCT;
        plan.cnt             = plan.cnt + 2'd1;
      end else if (phase_nxt == PH_DIGIT) begin
        plan.bytes[plan.cnt] = upd_pkg::CH_PCT;
        plan.bytes[plan.cnt + 2'd1] = held_nxt;
        plan.cnt             = plan.cnt + 2'd2;
      end
      phase_nxt = PH_IDLE;
      held_nxt  = 8'd0;
    end
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready && (plan.cnt != '0);
  assign q_plan   = plan;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      held_r  <= 8'd0;
    end else if (in_valid && in_ready) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

// File: rtl/core/upd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_queue
// Two-entry queue of byte plans between front and back.
// ----------------------------------------------------------------------------
module upd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  upd_pkg::plan_t push_plan,
  input  logic           pop,
  output logic           full,
  output logic           head_valid,
  output upd_pkg::plan_t head_plan
);

  upd_pkg::plan_t mem_r [upd_pkg::Q_DEPTH];
  logic [$clog2(upd_pkg::Q_DEPTH)-1:0] wr_ptr_r, rd_ptr_r;
  logic [$clog2(upd_pkg::Q_DEPTH+1)-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == ($clog2(upd_pkg::Q_DEPTH+1))'(upd_pkg::Q_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_plan  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_plan;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: rtl/core/upd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_back
// Serializer: walks the head plan one byte per cycle, unless the output is
// stalled, into the output register and tags the run and string ends.
// ----------------------------------------------------------------------------
module upd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_valid,
  input  upd_pkg::plan_t head_plan,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output upd_pkg::out_t  out_data
);

  logic [upd_pkg::CNT_W-1:0] idx_r, idx_nxt;
  logic                      out_valid_r;
  upd_pkg::out_t             out_r, out_nxt;
  logic                      load, last;

  assign load = head_valid && (!out_valid_r || out_ready);
  assign last = (idx_r == head_plan.cnt - 1'b1);
  assign pop  = load && last;

  always_comb begin
    out_nxt = '0;
    case (idx_r)
      2'd0:    out_nxt.out_char = head_plan.bytes[0];
      2'd1:    out_nxt.out_char = head_plan.bytes[1];
      2'd2:    out_nxt.out_char = head_plan.bytes[2];
      default: out_nxt.out_char = head_plan.bytes[0];
    endcase
    out_nxt.run_last   = last;
    out_nxt.string_end = last && head_plan.fin;
    idx_nxt            = last ? '0 : idx_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        idx_r       <= idx_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: rtl/core/url_percent_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_percent_decoder_top
// Streaming URL percent decoder: '%' plus two hex digits becomes one byte,
// broken escapes pass through literally, held characters flush at string end.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Payload                              Dir
//  -------   -------------------  -----------------------------------  ---
//  in_       in_valid / in_ready  in_data  {in_char, is_final}         in
//  out_      out_valid/out_ready  out_data {out_char, run_last,        out
//                                            string_end}
//
//  - One input transaction per cycle while each character yields at most
//    one byte and out_ready is high; a multi-byte character holds the
//    serializer until all its bytes are out.
//  - The output register emits one byte per cycle while out_ready is high; a
//    transaction's first byte passes queue write, then output register load.
//  - A two-entry plan queue separates the escape tracker from the serializer,
//    so in_ready drops only when the queue is full.
//  - Synchronous active-low reset returns to idle with nothing held and
//    empties the queue and output register.
//
module url_percent_decoder_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  upd_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output upd_pkg::out_t out_data
);

  // Front -> queue
  logic           q_push;
  logic           q_full;
  upd_pkg::plan_t q_plan;

  // Queue -> back
  logic           q_pop;
  logic           head_valid;
  upd_pkg::plan_t head_plan;

  // Escape tracker: holds '%' and the first hex digit, builds byte plans.
  upd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_plan   (q_plan)
  );

  // Characters that produce no bytes (held escapes) never enter the queue.
  upd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_plan  (q_plan),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_plan  (head_plan)
  );

  // Serializer: one byte per cycle unless the output is stalled, run_last on the plan's final byte.
  upd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_plan  (head_plan),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
